>>> rtl/rroc_pkg.sv
// Package for the relocation range overlap checker.
// Holds the item and status types, register indexes and fixed sizes.
// No dependencies.
package rroc_pkg;

  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned TYPE_W      = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned BITMAP_SPAN = 504;
  localparam int unsigned MAP_BITS    = 63;
  localparam int unsigned FIX_W_W     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_BASE   = 1'b0,
    CFG_RANGE_LENGTH = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_RELR = 1'b0,
    CMD_REL  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR      = 3'd0,
    ST_OVERLAP    = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_NO_BASE    = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_FAILED     = 3'd5
  } status_t;

  typedef struct packed {
    logic                command;
    logic                section_start;
    logic [ADDR_W-1:0]   entry_word;
    logic [TYPE_W-1:0]   fixup_type;
  } in_item_t;

endpackage

>>> rtl/rroc_in_if.sv
// Input item channel of the relocation range overlap checker.
// Depends on rroc_pkg for field widths.
interface rroc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic                         section_start;
  logic [rroc_pkg::ADDR_W-1:0]  entry_word;
  logic [rroc_pkg::TYPE_W-1:0]  fixup_type;

  modport source (output valid, command, section_start, entry_word, fixup_type,
                  input ready);
  modport sink   (input valid, command, section_start, entry_word, fixup_type,
                  output ready);
endinterface

>>> rtl/rroc_out_if.sv
// Result item channel of the relocation range overlap checker.
// Depends on rroc_pkg for the status type.
interface rroc_out_if;
  logic              valid;
  logic              ready;
  rroc_pkg::status_t status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

>>> rtl/relocation_range_overlap_checker_top.sv
// Top level of the relocation range overlap checker.
// Depends on rroc_pkg, rroc_in_if and rroc_out_if.
//
//   channel  dir  handshake       payload
//   in_ch    in   valid/ready     command, section_start, entry_word, fixup_type
//   out_ch   out  valid/ready     status (one item per input item)
//   cfg_*    in   cfg_we          cfg_index selects range_base / range_length
//
// Two register stages: input register, then result register. An accepted item
// waits in the input register; its status then moves to the result register
// and shows on out_ch.valid until taken. Throughput is one item per cycle while
// out_ch is not stalled, and the running RELR address updates with each item.
// Reset (rst_n low, synchronous) clears config, running address, base flag,
// sticky failure and both valid bits. A stalled out_ch holds its item; in_ch
// keeps accepting until both stages are full.
module relocation_range_overlap_checker_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rroc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rroc_pkg::ADDR_W-1:0]     cfg_wdata,
  rroc_in_if.sink                         in_ch,
  rroc_out_if.source                      out_ch
);

  localparam int unsigned AW = rroc_pkg::ADDR_W;
  localparam int unsigned LW = rroc_pkg::LEN_W;
  localparam int unsigned MB = rroc_pkg::MAP_BITS;
  localparam int unsigned FW = rroc_pkg::FIX_W_W;

  // Fixup width in bytes per x86-64 relocation type; unknown types are 16.
  function automatic logic [FW-1:0] fixup_width(input logic [rroc_pkg::TYPE_W-1:0] t);
    logic [FW-1:0] w;
    case (t) inside
      32'd0:                          w = FW'(0);
      32'd1, 32'd6, 32'd7, 32'd8, 32'd37: w = FW'(8);
      32'd2, 32'd4, 32'd9, 32'd10, 32'd11: w = FW'(4);
      32'd12, 32'd13:                 w = FW'(2);
      32'd14, 32'd15:                 w = FW'(1);
      default:                        w = FW'(16);
    endcase
    return w;
  endfunction

  // ---------------- configuration ----------------
  logic [AW-1:0] range_base_r;
  logic [LW-1:0] range_len_r;
  // range_base + range_length, kept one bit wider so bit AW flags overflow.
  logic [AW:0]   range_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_base_r <= '0;
      range_len_r  <= '0;
      range_end_r  <= '0;
    end else if (cfg_we) begin
      case (rroc_pkg::cfg_idx_t'(cfg_index))
        rroc_pkg::CFG_RANGE_BASE: begin
          range_base_r <= cfg_wdata;
          range_end_r  <= {1'b0, cfg_wdata} + (AW+1)'(range_len_r);
        end
        rroc_pkg::CFG_RANGE_LENGTH: begin
          range_len_r <= cfg_wdata[LW-1:0];
          range_end_r <= {1'b0, range_base_r} + (AW+1)'(cfg_wdata[LW-1:0]);
        end
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic               s1_v_r;
  rroc_pkg::in_item_t s1_r;
  logic               out_v_r;
  rroc_pkg::status_t  out_status_r;
  logic               s1_adv;
  logic               in_ready;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_v_r;
  assign out_ch.status = out_status_r;

  // ---------------- state ----------------
  logic [AW-1:0] next_addr_r, next_addr_nxt;
  logic          base_seen_r, base_seen_nxt;
  logic          failed_r, failed_nxt;
  rroc_pkg::status_t st_nxt;

  // Running state after an optional section restart.
  logic [AW-1:0] na_eff;
  logic          base_eff;

  // Single fixup check, shared by REL entries and RELR base words.
  logic [AW-1:0]  chk_addr;
  logic [FW-1:0]  chk_width;
  logic [AW:0]    chk_end;
  logic           range_ovf;
  logic           chk_ovf;
  logic           chk_hit;

  // Bitmap path.
  logic [MB-1:0]  marks;
  logic [AW:0]    room;        // 2^64 - running address
  logic [AW+1:0]  d1;          // range_base - running address
  logic [AW+1:0]  d2;          // range_end  - running address
  logic           room_small, d1_small, d2_small, d2_big;
  logic [MB-1:0]  ovf_vec, hit_vec, first_hit;
  logic [9:0]     lo, hi;
  logic [AW:0]    adv_sum;

  always_comb begin
    na_eff   = s1_r.section_start ? '0 : next_addr_r;
    base_eff = s1_r.section_start ? 1'b0 : base_seen_r;

    chk_addr  = s1_r.entry_word;
    chk_width = (s1_r.command == rroc_pkg::CMD_REL) ? fixup_width(s1_r.fixup_type)
                                                    : FW'(rroc_pkg::WORD_BYTES);
    chk_end   = {1'b0, chk_addr} + (AW+1)'(chk_width);
    range_ovf = range_end_r[AW];
    chk_ovf   = range_ovf || chk_end[AW];
    chk_hit   = ({1'b0, range_base_r} < chk_end) && ({1'b0, chk_addr} < range_end_r);

    // Bit k of marks covers running address + 8k. Each test is reduced to
    // three wide subtracts shared by all bits plus three 10-bit compares per bit.
    marks      = s1_r.entry_word[MB:1];
    room       = {1'b1, {AW{1'b0}}} - {1'b0, na_eff};
    d1         = {2'b00, range_base_r} - {2'b00, na_eff};
    d2         = {1'b0, range_end_r} - {2'b00, na_eff};
    room_small = (room[AW:9] == '0);
    d1_small   = !d1[AW+1] && (d1[AW:9] == '0);
    d2_small   = !d2[AW+1] && (d2[AW:9] == '0);
    d2_big     = !d2[AW+1] && (d2[AW:9] != '0);
    lo = '0;
    hi = '0;
    for (int k = 0; k < MB; k++) begin
      lo = 10'(k * rroc_pkg::WORD_BYTES);
      hi = 10'((k + 1) * rroc_pkg::WORD_BYTES);
      ovf_vec[k] = room_small && (hi >= {1'b0, room[8:0]});
      hit_vec[k] = marks[k] && (ovf_vec[k] ||
                   ((d1[AW+1] || (d1_small && ({1'b0, d1[8:0]} < hi))) &&
                    (d2_big || (d2_small && ({1'b0, d2[8:0]} > lo)))));
    end
    first_hit = hit_vec & (~hit_vec + MB'(1));
    adv_sum   = {1'b0, na_eff} + (AW+1)'(rroc_pkg::BITMAP_SPAN);

    // Status and state update.
    st_nxt        = rroc_pkg::ST_CLEAR;
    next_addr_nxt = na_eff;
    base_seen_nxt = base_eff;
    if (failed_r) begin
      st_nxt        = rroc_pkg::ST_FAILED;
      next_addr_nxt = next_addr_r;
      base_seen_nxt = base_seen_r;
    end else if (s1_r.command == rroc_pkg::CMD_REL) begin
      if (chk_width == '0)     st_nxt = rroc_pkg::ST_CLEAR;
      else if (chk_ovf)        st_nxt = rroc_pkg::ST_OVERFLOW;
      else if (chk_hit)        st_nxt = rroc_pkg::ST_OVERLAP;
    end else if (!s1_r.entry_word[0]) begin
      if (s1_r.entry_word[2:1] != 2'b00) st_nxt = rroc_pkg::ST_MISALIGNED;
      else if (chk_ovf)                  st_nxt = rroc_pkg::ST_OVERFLOW;
      else if (chk_hit)                  st_nxt = rroc_pkg::ST_OVERLAP;
      else begin
        next_addr_nxt = chk_end[AW-1:0];
        base_seen_nxt = 1'b1;
      end
    end else begin
      if (!base_eff)                    st_nxt = rroc_pkg::ST_NO_BASE;
      else if (range_ovf && (marks != '0)) st_nxt = rroc_pkg::ST_OVERFLOW;
      else if (hit_vec != '0)
        st_nxt = ((first_hit & ovf_vec) != '0) ? rroc_pkg::ST_OVERFLOW
                                               : rroc_pkg::ST_OVERLAP;
      else if (adv_sum[AW])             st_nxt = rroc_pkg::ST_OVERFLOW;
      else                              next_addr_nxt = adv_sum[AW-1:0];
    end
    failed_nxt = failed_r || (st_nxt != rroc_pkg::ST_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      next_addr_r <= '0;
      base_seen_r <= 1'b0;
      failed_r    <= 1'b0;
    end else begin
      if (in_ready) s1_v_r <= in_ch.valid;
      if (s1_adv) begin
        out_v_r     <= 1'b1;
        next_addr_r <= next_addr_nxt;
        base_seen_r <= base_seen_nxt;
        failed_r    <= failed_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_r.command       <= in_ch.command;
      s1_r.section_start <= in_ch.section_start;
      s1_r.entry_word    <= in_ch.entry_word;
      s1_r.fixup_type    <= in_ch.fixup_type;
    end
    if (s1_adv) out_status_r <= st_nxt;
  end

  // ---------------- assertions ----------------
  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("sticky failure flag dropped");

  a_failed_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && failed_r) |=> (out_status_r == rroc_pkg::ST_FAILED))
    else $error("item after failure did not answer earlier failure");

  a_error_sets_failed: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (st_nxt != rroc_pkg::ST_CLEAR)) |=> failed_r)
    else $error("error result did not set failure flag");

  a_failed_status_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_status_r == rroc_pkg::ST_FAILED)) |-> failed_r)
    else $error("earlier-failure status without failure flag");

  a_section_rel_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !failed_r && s1_r.section_start && (s1_r.command == rroc_pkg::CMD_REL))
    |=> (!base_seen_r && (next_addr_r == '0)))
    else $error("section start did not clear RELR state");

endmodule

>>> dv/relocation_range_overlap_checker_top_tb.sv
// Self-checking testbench for relocation_range_overlap_checker_top.
// Depends on rroc_pkg, rroc_in_if, rroc_out_if and the top level; an in-line
// predictor of the RELR/REL range check supplies the expected status stream.
module relocation_range_overlap_checker_top_tb;

  // x86-64 relocation type codes that select a fixup width
  localparam logic [31:0] RT_NONE      = 32'd0;
  localparam logic [31:0] RT_64        = 32'd1;
  localparam logic [31:0] RT_PC32      = 32'd2;
  localparam logic [31:0] RT_PLT32     = 32'd4;
  localparam logic [31:0] RT_GLOB_DAT  = 32'd6;
  localparam logic [31:0] RT_JUMP_SLOT = 32'd7;
  localparam logic [31:0] RT_RELATIVE  = 32'd8;
  localparam logic [31:0] RT_GOTPCREL  = 32'd9;
  localparam logic [31:0] RT_32        = 32'd10;
  localparam logic [31:0] RT_32S       = 32'd11;
  localparam logic [31:0] RT_16        = 32'd12;
  localparam logic [31:0] RT_PC16      = 32'd13;
  localparam logic [31:0] RT_8         = 32'd14;
  localparam logic [31:0] RT_PC8       = 32'd15;
  localparam logic [31:0] RT_IRELATIVE = 32'd37;

  // ~900 items with gaps and stalls; the limit sits well above what they need
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 150;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rroc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rroc_pkg::ADDR_W-1:0]    cfg_wdata;

  rroc_in_if  in_ch();
  rroc_out_if out_ch();

  relocation_range_overlap_checker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor copy of the block: range registers, running RELR state and sticky failure.
  logic [63:0] rng_base;
  logic [31:0] rng_len;
  logic [63:0] run_addr;
  logic        base_seen;
  logic        sticky_fail;

  rroc_pkg::status_t expected_status[$];
  rroc_pkg::status_t want;
  int unsigned fail_count;
  int unsigned item_count;
  int unsigned cycle_count;
  int unsigned rx_hold;
  logic        calm;   // set for the last part of the run: no gaps, no stalls

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [4:0] width_of(input logic [31:0] code);
    case (code)
      RT_NONE: return 5'd0;
      RT_64, RT_GLOB_DAT, RT_JUMP_SLOT, RT_RELATIVE, RT_IRELATIVE: return 5'd8;
      RT_PC32, RT_PLT32, RT_GOTPCREL, RT_32, RT_32S: return 5'd4;
      RT_16, RT_PC16: return 5'd2;
      RT_8, RT_PC8: return 5'd1;
      default: return 5'd16;   // unknown codes count as 16-byte fixups
    endcase
  endfunction

  // Fixup [addr, addr+w) against the protected range; sums carried in 65 bits
  // so that a carry out of bit 63 is the overflow flag.
  function automatic rroc_pkg::status_t fixup_status(input logic [63:0] addr,
                                                     input logic [4:0] w);
    logic [64:0] rng_end;
    logic [64:0] fix_end;
    rng_end = {1'b0, rng_base} + {33'd0, rng_len};
    fix_end = {1'b0, addr} + {60'd0, w};
    if (rng_end[64] || fix_end[64]) return rroc_pkg::ST_OVERFLOW;
    if ({1'b0, rng_base} < fix_end && {1'b0, addr} < rng_end) return rroc_pkg::ST_OVERLAP;
    return rroc_pkg::ST_CLEAR;
  endfunction

  // Status of one item from the given running state; next state on the side.
  // On an error the next state is meaningless since the failure sticks.
  function automatic rroc_pkg::status_t judge(input rroc_pkg::in_item_t it,
                                              input logic [63:0] addr_in,
                                              input logic seen_in,
                                              output logic [63:0] addr_out,
                                              output logic seen_out);
    rroc_pkg::status_t st;
    logic [63:0] w;
    logic [64:0] slot;
    int          b;
    addr_out = it.section_start ? 64'd0 : addr_in;
    seen_out = it.section_start ? 1'b0 : seen_in;
    w = it.entry_word;
    if (it.command == rroc_pkg::CMD_REL) begin
      if (width_of(it.fixup_type) == 5'd0) return rroc_pkg::ST_CLEAR;
      return fixup_status(w, width_of(it.fixup_type));
    end
    if (!w[0]) begin
      // base word: one 8-byte fixup, must be 8-aligned
      if (w[2:0] != 3'd0) return rroc_pkg::ST_MISALIGNED;
      st = fixup_status(w, 5'(rroc_pkg::WORD_BYTES));
      if (st != rroc_pkg::ST_CLEAR) return st;
      addr_out = w + 64'(rroc_pkg::WORD_BYTES);
      seen_out = 1'b1;
      return rroc_pkg::ST_CLEAR;
    end
    if (!seen_out) return rroc_pkg::ST_NO_BASE;
    // bitmap: lowest marked bit that fails decides
    for (b = 1; b < 64; b++) begin
      if (w[b]) begin
        slot = {1'b0, addr_out} + 65'((b - 1) * rroc_pkg::WORD_BYTES);
        if (slot[64]) return rroc_pkg::ST_OVERFLOW;
        st = fixup_status(slot[63:0], 5'(rroc_pkg::WORD_BYTES));
        if (st != rroc_pkg::ST_CLEAR) return st;
      end
    end
    slot = {1'b0, addr_out} + 65'(rroc_pkg::BITMAP_SPAN);
    if (slot[64]) return rroc_pkg::ST_OVERFLOW;
    addr_out = slot[63:0];
    return rroc_pkg::ST_CLEAR;
  endfunction

  // Commit one accepted item to the predictor state.
  function automatic rroc_pkg::status_t predict_status(input rroc_pkg::in_item_t it);
    rroc_pkg::status_t st;
    logic [63:0] a;
    logic        s;
    if (sticky_fail) return rroc_pkg::ST_FAILED;
    st = judge(it, run_addr, base_seen, a, s);
    run_addr  = a;
    base_seen = s;
    if (st != rroc_pkg::ST_CLEAR) sticky_fail = 1'b1;
    return st;
  endfunction

  // True when the item would come back clear from the current state.
  function automatic logic passes(input rroc_pkg::in_item_t it);
    logic [63:0] a;
    logic        s;
    return !sticky_fail && judge(it, run_addr, base_seen, a, s) == rroc_pkg::ST_CLEAR;
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------

  function automatic rroc_pkg::in_item_t pack_item(input rroc_pkg::cmd_t cmd,
                                                   input logic sec,
                                                   input logic [63:0] word,
                                                   input logic [31:0] code);
    rroc_pkg::in_item_t it;
    it.command       = cmd;
    it.section_start = sec;
    it.entry_word    = word;
    it.fixup_type    = code;
    return it;
  endfunction

  function automatic logic [31:0] pick_type();
    case ($urandom_range(0, 17))
      0:  return RT_NONE;
      1:  return RT_64;
      2:  return RT_PC32;
      3:  return RT_PLT32;
      4:  return RT_GLOB_DAT;
      5:  return RT_JUMP_SLOT;
      6:  return RT_RELATIVE;
      7:  return RT_GOTPCREL;
      8:  return RT_32;
      9:  return RT_32S;
      10: return RT_16;
      11: return RT_PC16;
      12: return RT_8;
      13: return RT_PC8;
      14: return RT_IRELATIVE;
      15: return 32'($urandom_range(0, 63));
      default: return $urandom;
    endcase
  endfunction

  // Address just below or around an edge of the range or a point inside it, or anywhere.
  function automatic logic [63:0] near_range(input int unsigned span);
    logic [63:0] anchor;
    case ($urandom_range(0, 3))
      0: anchor = rng_base;
      1: anchor = rng_base + 64'(rng_len);
      2: anchor = {$urandom, $urandom};
      default: anchor = rng_base + 64'($urandom) % (64'(rng_len) + 64'd1);
    endcase
    return anchor - 64'($urandom_range(0, span)) + 64'($urandom_range(0, 16));
  endfunction

  // Random bitmap whose marks all stay clear of the range and the top of memory.
  function automatic logic [63:0] marked_bitmap();
    logic [63:0] mask;
    logic [64:0] slot;
    int          b;
    mask = 64'd1;
    for (b = 1; b < 64; b++) begin
      slot = {1'b0, run_addr} + 65'((b - 1) * rroc_pkg::WORD_BYTES);
      if (!slot[64] &&
          fixup_status(slot[63:0], 5'(rroc_pkg::WORD_BYTES)) == rroc_pkg::ST_CLEAR)
        mask[b] = 1'b1;
    end
    if ($urandom_range(0, 7) == 0) return mask;   // every safe word marked
    return ({$urandom, $urandom} & mask) | 64'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Offer one item, wait for the handshake, log the expected status.
  task automatic send_item(input rroc_pkg::in_item_t it);
    rroc_pkg::status_t st;
    if (!calm && !cycle_count[9] && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= it.command;
    in_ch.section_start <= it.section_start;
    in_ch.entry_word    <= it.entry_word;
    in_ch.fixup_type    <= it.fixup_type;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    st = predict_status(it);
    expected_status.insert(expected_status.size(), st);
    item_count++;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers back to back; only called with the block idle.
  task automatic set_range(input logic [63:0] base, input logic [63:0] len_word);
    cfg_we    <= 1'b1;
    cfg_index <= rroc_pkg::CFG_RANGE_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    rng_base  = base;
    cfg_index <= rroc_pkg::CFG_RANGE_LENGTH;
    cfg_wdata <= len_word;
    @(posedge clk);
    rng_len   = len_word[31:0];
    cfg_we    <= 1'b0;
  endtask

  // REL item near the range; falls back to a NONE entry if nothing stays clear.
  task automatic rel_near_range();
    rroc_pkg::in_item_t it;
    int unsigned tries;
    tries = 0;
    do begin
      it = pack_item(rroc_pkg::CMD_REL, 1'($urandom_range(0, 1)), near_range(24),
                     pick_type());
      tries++;
    end while (!passes(it) && tries < 8);
    if (!passes(it)) it.fixup_type = RT_NONE;
    send_item(it);
  endtask

  // New section: base word near the range, then bitmaps that sweep upward from it.
  task automatic relr_section();
    rroc_pkg::in_item_t it;
    int unsigned tries;
    tries = 0;
    do begin
      it = pack_item(rroc_pkg::CMD_RELR, 1'b1, near_range(1100) & ~64'd7, $urandom);
      tries++;
    end while (!passes(it) && tries < 8);
    if (!passes(it)) return;
    send_item(it);
    repeat ($urandom_range(1, 8)) begin
      it.section_start = 1'b0;
      it.fixup_type    = $urandom;
      if ($urandom_range(0, 9) == 0) it.entry_word = near_range(1100) & ~64'd7;   // rebase
      else                           it.entry_word = marked_bitmap();
      if (!passes(it)) return;   // e.g. the 504-byte step would wrap
      send_item(it);
      // REL entries inside a RELR run must not disturb the running address
      if ($urandom_range(0, 7) == 0) begin
        it = pack_item(rroc_pkg::CMD_REL, 1'b0, {$urandom, $urandom}, pick_type());
        if (!passes(it)) it.fixup_type = RT_NONE;
        send_item(it);
      end
    end
  endtask

  task automatic random_burst();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: relr_section();
      6, 7, 8:          rel_near_range();
      default: begin
        // noise: arbitrary offsets and type codes
        if (!passes(pack_item(rroc_pkg::CMD_REL, 1'b0, {$urandom, $urandom}, $urandom)))
          send_item(pack_item(rroc_pkg::CMD_REL, 1'($urandom_range(0, 1)),
                              {$urandom, $urandom}, RT_NONE));
        else
          send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, {$urandom, $urandom}, $urandom));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config (empty range at 0): every width, NONE, unknown codes, base and
  // bitmap words, rebase mid-section, REL inside a section, top of memory.
  task automatic test_directed_defaults();
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b1, 64'd0, RT_NONE));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, '1, RT_NONE));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, 64'd0, RT_64));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, 64'd0, RT_PC32));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, 64'd0, RT_16));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, 64'd0, RT_8));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, 64'd0, '1));
    // 16 bytes ending one byte below the top
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, '1 - 64'd16, RT_PC8 + 32'd1));
    send_item(pack_item(rroc_pkg::CMD_RELR, 1'b1, 64'd0, $urandom));
    send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, '1, $urandom));
    send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, 64'd1, $urandom));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, 64'h1234_5678_9abc_def0, RT_GOTPCREL));
    send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, 64'hAAAA_AAAA_AAAA_AAAB, $urandom));
    send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, 64'hFFFF_FFFF_FFFF_FC00, $urandom));
    send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, '1, $urandom));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b1, 64'h8000_0000_0000_0000, RT_IRELATIVE));
    send_item(pack_item(rroc_pkg::CMD_RELR, 1'b1, 64'h7FFF_FFFF_FFFF_FFF8, $urandom));
    send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, 64'h8000_0000_0000_0001, $urandom));
    send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, 64'h0000_0000_FFFF_FFFF, RT_32S));
  endtask

  // Range [0, 2^32 - 1), the longest length; only NONE entries are sent.
  // Upper data bits of the length write must be dropped.
  task automatic test_full_length_range();
    drain_results();
    set_range(64'd0, {$urandom, 32'hFFFF_FFFF});
    repeat (6)
      send_item(pack_item(rroc_pkg::CMD_REL, 1'($urandom_range(0, 1)),
                          {$urandom, $urandom}, RT_NONE));
  endtask

  // Empty range at the very top of memory, where most sums wrap.
  task automatic test_top_of_space();
    drain_results();
    set_range('1, {$urandom, 32'd0});
    while (item_count < 90) random_burst();
  endtask

  // Several random ranges, small to full length, mostly well-formed sections.
  task automatic test_random_ranges();
    logic [63:0] base;
    logic [31:0] len;
    int unsigned k;
    for (k = 0; k < 5; k++) begin
      drain_results();   // sender holds until every result is back
      case (k)
        0, 4: len = 32'($urandom_range(0, 64));
        1:    len = 32'($urandom_range(0, 4096));
        2:    len = $urandom;
        default: len = 32'hFFFF_FFFF;
      endcase
      base = (k == 1) ? 64'($urandom_range(0, 2048)) : {$urandom, $urandom};
      if (base > ~{32'd0, len}) base = ~{32'd0, len} - 64'($urandom_range(0, 4096));
      set_range(base, {$urandom, len});
      calm = (k == 4);
      while (item_count < 90 + (k + 1) * PHASE_ITEMS) random_burst();
    end
  endtask

  // One error of a randomly chosen kind, then items that must all report the
  // sticky failure whatever they carry.
  task automatic test_sticky_failure();
    logic [63:0] spot;
    drain_results();
    spot = ({$urandom, $urandom} >> 2) + 64'd4096;
    case ($urandom_range(0, 7))
      0: begin   // REL overlap; fixup strictly contains the range start
        set_range(spot, 64'($urandom_range(0, 64)));
        send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, spot - 64'd4, RT_64));
      end
      1: send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0,
                             ({$urandom, $urandom} & ~64'd7) | 64'(2 * $urandom_range(1, 3)),
                             $urandom));
      2: send_item(pack_item(rroc_pkg::CMD_RELR, 1'b1, {$urandom, $urandom} | 64'd1,
                             $urandom));
      3: send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, '1 - 64'($urandom_range(0, 6)),
                             RT_64));
      4: begin   // marked word past the top of memory
        set_range(64'd0, 64'd0);
        send_item(pack_item(rroc_pkg::CMD_RELR, 1'b1, '1 - 64'd63, $urandom));
        send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, {1'b1, 62'($urandom), 1'b1},
                            $urandom));
      end
      5: begin   // 504-byte step wraps
        set_range(64'd0, 64'd0);
        send_item(pack_item(rroc_pkg::CMD_RELR, 1'b1, '1 - 64'd511, $urandom));
        send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, 64'd1, $urandom));
      end
      6: begin   // range end itself wraps
        set_range('1, 64'($urandom_range(1, 32'hFFFF_FFFF)));
        send_item(pack_item(rroc_pkg::CMD_REL, 1'b0, {$urandom, $urandom} >> 1, RT_PC32));
      end
      default: begin   // bitmap mark lands in the range
        set_range(spot, 64'd16);
        send_item(pack_item(rroc_pkg::CMD_RELR, 1'b1, (spot & ~64'd7) - 64'd64, $urandom));
        send_item(pack_item(rroc_pkg::CMD_RELR, 1'b0, '1, $urandom));
      end
    endcase
    repeat (12)
      send_item(pack_item(rroc_pkg::cmd_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          {$urandom, $urandom}, pick_type()));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on ready, with quiet stretches
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (!calm && !cycle_count[8] && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_status.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with nothing pending: status %0d", out_ch.status);
      end else begin
        want = expected_status.pop_front();
        if (out_ch.status !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("status mismatch: expected %0d (%s) actual %0d",
                     want, want.name(), out_ch.status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("relocation_range_overlap_checker_top_tb failed");
      $finish;
    end
  end

  initial begin
    rng_base    = '0;
    rng_len     = '0;
    run_addr    = '0;
    base_seen   = 1'b0;
    sticky_fail = 1'b0;
    fail_count  = 0;
    item_count  = 0;
    cycle_count = 0;
    rx_hold     = 0;
    calm        = 1'b0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= rroc_pkg::CFG_RANGE_BASE;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= rroc_pkg::CMD_RELR;
    in_ch.section_start <= 1'b0;
    in_ch.entry_word    <= '0;
    in_ch.fixup_type    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_full_length_range();
    test_top_of_space();
    test_random_ranges();
    test_sticky_failure();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_status.size() == 0) begin
      $display("relocation_range_overlap_checker_top_tb passed");
    end else begin
      $display("relocation_range_overlap_checker_top_tb failed");
    end
    $finish;
  end

endmodule
